### hdl/frustum_box_cull_assert.svh
// Assertion helpers shared by the frustum box cull RTL.
`ifndef FRUSTUM_BOX_CULL_ASSERT_SVH
`define FRUSTUM_BOX_CULL_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FBC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frustum_box_cull assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frustum_box_cull assertion failed");

`endif

### hdl/fbc_pkg.sv
package fbc_pkg;

    localparam int REG_COUNT    = 6;
    localparam int NORMAL_BITS  = 16;
    localparam int FRAC_BITS    = 14;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_ADDR_W   = 6;
    localparam int CFG_INDEX_LSB = 3;
    localparam int CFG_INDEX_W  = CFG_ADDR_W - CFG_INDEX_LSB;

    typedef struct packed {
        logic signed [NORMAL_BITS-1:0] d;
        logic signed [NORMAL_BITS-1:0] nz;
        logic signed [NORMAL_BITS-1:0] ny;
        logic signed [NORMAL_BITS-1:0] nx;
    } t_plane;

    typedef struct packed {
        logic all_out;
        logic any_out;
    } t_plane_flags;

    typedef enum logic [1:0] {
        VERDICT_FULL_IN  = 2'd0,
        VERDICT_IN_NEAR  = 2'd1,
        VERDICT_FULL_OUT = 2'd2
    } t_verdict;

endpackage

### hdl/fbc_plane_regs.sv
module fbc_plane_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fbc_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [fbc_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [fbc_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready,
    output fbc_pkg::t_plane                   o_planes [fbc_pkg::REG_COUNT]
);
    import fbc_pkg::*;

    t_plane                 r_planes [REG_COUNT];
    logic [CFG_INDEX_W-1:0] w_index;
    logic                   w_write;
    logic                   w_in_range;

    assign pready     = 1'b1;
    assign w_index    = paddr[CFG_ADDR_W-1:CFG_INDEX_LSB];
    assign w_in_range = (w_index < CFG_INDEX_W'(REG_COUNT));
    assign w_write    = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REG_COUNT; i++) begin
                r_planes[i] <= '0;
            end
        end else if (w_write) begin
            for (int i = 0; i < REG_COUNT; i++) begin
                if (w_index == CFG_INDEX_W'(i)) begin
                    r_planes[i] <= t_plane'(pwdata);
                end
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (w_in_range) begin
            prdata = CFG_DATA_W'(r_planes[w_index]);
        end
    end

    assign o_planes = r_planes;

endmodule

### hdl/fbc_plane_eval.sv
module fbc_plane_eval #(
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_load,
    input  fbc_pkg::t_plane              i_plane,
    input  logic signed [COORD_BITS-1:0] i_big [3],
    input  logic signed [COORD_BITS-1:0] i_sml [3],
    output fbc_pkg::t_plane_flags        o_flags
);
    import fbc_pkg::*;

    localparam int PROD_W = NORMAL_BITS + COORD_BITS;
    localparam int BASE_W = (PROD_W > NORMAL_BITS + FRAC_BITS) ? PROD_W
                                                                : NORMAL_BITS + FRAC_BITS;
    localparam int SUM_W  = BASE_W + 2;

    logic signed [NORMAL_BITS-1:0] w_n [3];
    logic signed [COORD_BITS-1:0]  w_cmax [3];
    logic signed [COORD_BITS-1:0]  w_cmin [3];
    logic signed [PROD_W-1:0]      n_pmax [3];
    logic signed [PROD_W-1:0]      n_pmin [3];
    logic signed [PROD_W-1:0]      r_pmax [3];
    logic signed [PROD_W-1:0]      r_pmin [3];
    logic signed [SUM_W-1:0]       w_dterm;
    logic signed [SUM_W-1:0]       w_smax;
    logic signed [SUM_W-1:0]       w_smin;

    assign w_n[0] = i_plane.nx;
    assign w_n[1] = i_plane.ny;
    assign w_n[2] = i_plane.nz;

    // The largest corner value takes the larger coordinate on each axis with a
    // positive coefficient and the smaller one otherwise; the smallest is the mirror.
    for (genvar a = 0; a < 3; a++) begin : g_axis
        assign w_cmax[a] = w_n[a][NORMAL_BITS-1] ? i_sml[a] : i_big[a];
        assign w_cmin[a] = w_n[a][NORMAL_BITS-1] ? i_big[a] : i_sml[a];
        assign n_pmax[a] = w_n[a] * w_cmax[a];
        assign n_pmin[a] = w_n[a] * w_cmin[a];

        always_ff @(posedge i_clk) begin
            if (i_load) begin
                r_pmax[a] <= n_pmax[a];
                r_pmin[a] <= n_pmin[a];
            end
        end
    end

    assign w_dterm = SUM_W'(i_plane.d) <<< FRAC_BITS;
    assign w_smax  = SUM_W'(r_pmax[0]) + SUM_W'(r_pmax[1]) + SUM_W'(r_pmax[2]) + w_dterm;
    assign w_smin  = SUM_W'(r_pmin[0]) + SUM_W'(r_pmin[1]) + SUM_W'(r_pmin[2]) + w_dterm;

    assign o_flags.all_out = w_smax[SUM_W-1] || (w_smax == '0);
    assign o_flags.any_out = w_smin[SUM_W-1] || (w_smin == '0);

endmodule

### hdl/frustum_box_cull.sv
// Channel   | Valid        | Stall        | Payload
// ----------+--------------+--------------+--------------------------------------
// box in    | i_in_valid   | o_in_stall   | i_min_x/y/z, i_max_x/y/z
// verdict   | o_out_valid  | i_out_stall  | o_verdict
// config    | psel/penable | pready       | paddr, pwdata, prdata (64-bit planes)
//
// One box is accepted per cycle unless o_in_stall is asserted; its verdict passes through the stages in order.
// The stages are the input register, the corner product register and the verdict register.
// While the output is stalled the earlier stages keep filling, and the input stalls only
// once all three stages hold a transaction.
// Reset is synchronous; it clears the plane registers and all stage valid flags.
`include "frustum_box_cull_assert.svh"

module frustum_box_cull #(
    parameter int PLANE_COUNT = 6,
    parameter int COORD_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [COORD_BITS-1:0]        i_min_x,
    input  logic signed [COORD_BITS-1:0]        i_min_y,
    input  logic signed [COORD_BITS-1:0]        i_min_z,
    input  logic signed [COORD_BITS-1:0]        i_max_x,
    input  logic signed [COORD_BITS-1:0]        i_max_y,
    input  logic signed [COORD_BITS-1:0]        i_max_z,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [1:0]                          o_verdict,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fbc_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [fbc_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [fbc_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready
);
    import fbc_pkg::*;

    localparam int TESTED = (PLANE_COUNT < REG_COUNT) ? PLANE_COUNT : REG_COUNT;

    t_plane                       w_planes [REG_COUNT];
    t_plane_flags                 w_flags [TESTED];
    logic signed [COORD_BITS-1:0] r_lo [3];
    logic signed [COORD_BITS-1:0] r_hi [3];
    logic signed [COORD_BITS-1:0] w_big [3];
    logic signed [COORD_BITS-1:0] w_sml [3];
    logic                         r_v0;
    logic                         r_v1;
    logic                         r_out_valid;
    t_verdict                     r_verdict;
    t_verdict                     n_verdict;
    logic                         w_ready0;
    logic                         w_ready1;
    logic                         w_ready2;
    logic                         w_in_acc;
    logic                         w_out_acc;
    logic                         w_culled;

    fbc_plane_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_planes (w_planes)
    );

    assign w_ready2  = !r_out_valid || !i_out_stall;
    assign w_ready1  = !r_v1 || w_ready2;
    assign w_ready0  = !r_v0 || w_ready1;
    assign w_in_acc  = i_in_valid && w_ready0;
    assign w_out_acc = r_out_valid && !i_out_stall;

    assign o_in_stall  = !w_ready0;
    assign o_out_valid = r_out_valid;
    assign o_verdict   = r_verdict;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0        <= 1'b0;
            r_v1        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_ready0) begin
                r_v0 <= i_in_valid;
            end
            if (w_ready1) begin
                r_v1 <= r_v0;
            end
            if (w_ready2) begin
                r_out_valid <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_lo[0] <= i_min_x;
            r_lo[1] <= i_min_y;
            r_lo[2] <= i_min_z;
            r_hi[0] <= i_max_x;
            r_hi[1] <= i_max_y;
            r_hi[2] <= i_max_z;
        end
        if (w_ready2 && r_v1) begin
            r_verdict <= n_verdict;
        end
    end

    for (genvar a = 0; a < 3; a++) begin : g_order
        assign w_big[a] = (r_hi[a] >= r_lo[a]) ? r_hi[a] : r_lo[a];
        assign w_sml[a] = (r_hi[a] >= r_lo[a]) ? r_lo[a] : r_hi[a];
    end

    for (genvar p = 0; p < TESTED; p++) begin : g_plane
        fbc_plane_eval #(
            .COORD_BITS (COORD_BITS)
        ) u_eval (
            .i_clk   (i_clk),
            .i_load  (w_ready1 && r_v0),
            .i_plane (w_planes[p]),
            .i_big   (w_big),
            .i_sml   (w_sml),
            .o_flags (w_flags[p])
        );
    end

    always_comb begin
        w_culled = 1'b0;
        for (int p = 0; p < TESTED; p++) begin
            w_culled = w_culled || w_flags[p].all_out;
        end
        if (w_culled) begin
            n_verdict = VERDICT_FULL_OUT;
        end else if (w_flags[0].any_out) begin
            n_verdict = VERDICT_IN_NEAR;
        end else begin
            n_verdict = VERDICT_FULL_IN;
        end
    end

    `FBC_ASSERT_NEXT(a_accept_fills_stage, i_clk, i_rst_n, w_in_acc, r_v0)
    `FBC_ASSERT_NOW(a_empty_never_stalls, i_clk, i_rst_n, !r_v0, !o_in_stall)
    `FBC_ASSERT_NEXT(a_drain_when_empty, i_clk, i_rst_n, w_out_acc && !r_v1, !o_out_valid)
    `FBC_ASSERT_NOW(a_verdict_code, i_clk, i_rst_n, o_out_valid, o_verdict <= VERDICT_FULL_OUT)

endmodule
